// ===== rtl/core/psd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psd_pkg
// shared constants for the placement signature dense id block
// ---------------------------------------------------------------------------
package psd_pkg;

  localparam int unsigned SIG_W         = 64;
  localparam int unsigned NUM_MAP_W     = 7;
  localparam logic [NUM_MAP_W-1:0] NUM_MAP_RESET = 7'd64;
  localparam int unsigned GROUP_ID_W    = 10;
  localparam int unsigned GROUP_COUNT_W = 11;

  // hash mix: xor fold, golden ratio multiply, xor fold
  localparam int unsigned HASH_SHIFT = 29;
  localparam int unsigned HASH_FOLD  = 32;
  localparam logic [SIG_W-1:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;

  // table entries carry an epoch tag, zero marks an entry as empty
  localparam int unsigned EPOCH_W = 8;

  // front to back queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  // remainder bits per cycle for a table size that is no power of two
  localparam int unsigned MOD_BITS_PER_STEP = 8;

endpackage

`default_nettype wire

// ===== rtl/core/psd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psd_node_if / psd_group_if
// valid/ready channels for node requests and group results
// ---------------------------------------------------------------------------
interface psd_node_if import psd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SIG_W-1:0] placement_bits;
  logic             start_set;

  modport source (output valid, output placement_bits, output start_set, input ready);
  modport sink   (input valid, input placement_bits, input start_set, output ready);
endinterface

interface psd_group_if import psd_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [GROUP_ID_W-1:0]    group_id;
  logic                     is_new;
  logic                     overflow;
  logic [GROUP_COUNT_W-1:0] group_count;

  modport source (output valid, output group_id, output is_new, output overflow,
                  output group_count, input ready);
  modport sink   (input valid, input group_id, input is_new, input overflow,
                  input group_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/psd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psd_front
// accepts node requests, masks the signature and computes its home slot
// ---------------------------------------------------------------------------
module psd_front import psd_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned MAX_MAPPINGS  = 64,
  localparam int unsigned SLOT_W  = $clog2(TABLE_ENTRIES),
  localparam int unsigned ENTRY_W = 1 + SLOT_W + MAX_MAPPINGS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 init_done_i,
  input  logic [NUM_MAP_W-1:0] num_map_i,
  psd_node_if.sink             node_i,
  output logic                 push_valid_o,
  output logic [ENTRY_W-1:0]   push_data_o,
  input  logic                 push_ready_i
);

  localparam int unsigned KW = MAX_MAPPINGS;
  localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  logic          v0_q, v1_q, v2_q;
  logic          adv0, adv1, adv2;
  logic          in_fire;
  logic [KW-1:0] key_in;
  logic [KW-1:0] key0_q, key1_q, key2_q;
  logic          st0_q, st1_q, st2_q;
  logic [SIG_W-1:0] x_w, h_w, f_w;
  logic [SIG_W-1:0] p0_q;
  logic [31:0]      p1_q, p2_q;
  logic [SIG_W-1:0] f2_q;

  // keep only the bits below num_mappings
  always_comb begin
    for (int i = 0; i < KW; i++) begin
      key_in[i] = node_i.placement_bits[i] & (NUM_MAP_W'(i) < num_map_i);
    end
  end

  assign adv0         = v0_q & (~v1_q | adv1);
  assign adv1         = v1_q & (~v2_q | adv2);
  assign node_i.ready = init_done_i & (~v0_q | adv0);
  assign in_fire      = node_i.valid & node_i.ready;

  // stage 1: xor fold and 32-bit partial products
  assign x_w = SIG_W'(key0_q) ^ (SIG_W'(key0_q) >> HASH_SHIFT);

  // stage 2: low 64 bits of the product, then xor fold
  assign h_w = p0_q + {p1_q + p2_q, 32'b0};
  assign f_w = h_w ^ (h_w >> HASH_FOLD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= in_fire | (v0_q & ~adv0);
      v1_q <= adv0 | (v1_q & ~adv1);
      v2_q <= adv1 | (v2_q & ~adv2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key0_q <= key_in;
      st0_q  <= node_i.start_set;
    end
    if (adv0) begin
      key1_q <= key0_q;
      st1_q  <= st0_q;
      p0_q   <= SIG_W'(x_w[31:0]) * SIG_W'(HASH_MUL[31:0]);
      p1_q   <= x_w[63:32] * HASH_MUL[31:0];
      p2_q   <= x_w[31:0] * HASH_MUL[63:32];
    end
    if (adv1) begin
      key2_q <= key1_q;
      st2_q  <= st1_q;
      f2_q   <= f_w;
    end
  end

  if (IS_POW2) begin : g_pow2
    assign adv2         = v2_q & push_ready_i;
    assign push_valid_o = v2_q;
    assign push_data_o  = {st2_q, f2_q[SLOT_W-1:0], key2_q};
  end else begin : g_mod
    localparam int unsigned MOD_STEPS = SIG_W / MOD_BITS_PER_STEP;
    localparam int unsigned MC_W      = $clog2(MOD_STEPS);
    localparam logic [SLOT_W:0] TE    = (SLOT_W + 1)'(TABLE_ENTRIES);

    logic              mv_q, md_q;
    logic [MC_W-1:0]   mc_q;
    logic [SIG_W-1:0]  msh_q;
    logic [SLOT_W-1:0] rem_q, rem_nx;
    logic [KW-1:0]     key3_q;
    logic              st3_q;
    logic              push;

    // remainder by the table size, a few bits per cycle, msb first
    always_comb begin
      logic [SLOT_W:0] t;
      rem_nx = rem_q;
      for (int b = 0; b < MOD_BITS_PER_STEP; b++) begin
        t = {rem_nx, msh_q[SIG_W-1-b]};
        if (t >= TE) begin
          t = t - TE;
        end
        rem_nx = t[SLOT_W-1:0];
      end
    end

    assign push         = mv_q & md_q & push_ready_i;
    assign adv2         = v2_q & (~mv_q | push);
    assign push_valid_o = mv_q & md_q;
    assign push_data_o  = {st3_q, rem_q, key3_q};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q <= 1'b0;
        md_q <= 1'b0;
        mc_q <= '0;
      end else if (adv2) begin
        mv_q <= 1'b1;
        md_q <= 1'b0;
        mc_q <= '0;
      end else if (push) begin
        mv_q <= 1'b0;
      end else if (mv_q && !md_q) begin
        mc_q <= mc_q + 1'b1;
        if (mc_q == MC_W'(MOD_STEPS - 1)) begin
          md_q <= 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv2) begin
        msh_q  <= f2_q;
        rem_q  <= '0;
        key3_q <= key2_q;
        st3_q  <= st2_q;
      end else if (mv_q && !md_q) begin
        msh_q <= msh_q << MOD_BITS_PER_STEP;
        rem_q <= rem_nx;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/psd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psd_fifo
// short queue of classified requests between front and back
// ---------------------------------------------------------------------------
module psd_fifo import psd_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o,
  input  logic             pop_ready_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wp_q, rp_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rp_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/psd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psd_back
// probes the key table, inserts new signatures and returns group ids
// ---------------------------------------------------------------------------
module psd_back import psd_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned MAX_MAPPINGS  = 64,
  localparam int unsigned SLOT_W  = $clog2(TABLE_ENTRIES),
  localparam int unsigned QE_W    = 1 + SLOT_W + MAX_MAPPINGS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  input  logic [QE_W-1:0]   pop_data_i,
  output logic              pop_ready_o,
  output logic              init_done_o,
  psd_group_if.source       group_o
);

  localparam int unsigned KW    = MAX_MAPPINGS;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned MEM_W = EPOCH_W + KW + GROUP_ID_W;

  typedef enum logic [3:0] {
    ST_CLR  = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_RD   = 4'b0100,
    ST_CMP  = 4'b1000
  } psd_back_state_e;

  psd_back_state_e state_q, state_d;
  logic [SLOT_W-1:0]  clr_idx_q, clr_idx_d;
  logic               pend_q, pend_d;
  logic [EPOCH_W-1:0] ep_q, ep_d;
  logic [CNT_W-1:0]   nid_q, nid_d;
  logic [KW-1:0]      key_q, key_d;
  logic [SLOT_W-1:0]  slot_q, slot_d, slot_nx;
  logic [SLOT_W-1:0]  probe_q, probe_d;

  logic [MEM_W-1:0]  mem_q [TABLE_ENTRIES];
  logic [MEM_W-1:0]  rd_q;
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_wa, mem_ra;
  logic [MEM_W-1:0]  mem_wd;

  logic                     oq_v_q, oq_v_d;
  logic [GROUP_ID_W-1:0]    oid_q, oid_d;
  logic                     onew_q, onew_d;
  logic                     oovf_q, oovf_d;
  logic [GROUP_COUNT_W-1:0] ocnt_q, ocnt_d;

  logic                     q_start;
  logic [SLOT_W-1:0]        q_slot;
  logic [KW-1:0]            q_key;
  logic [EPOCH_W-1:0]       rd_ep;
  logic [KW-1:0]            rd_key;
  logic [GROUP_ID_W-1:0]    rd_id;
  logic                     slot_empty, key_hit, probe_last, out_free;
  logic [CNT_W-1:0]         nid_inc;
  logic [CNT_W+GROUP_COUNT_W-1:0] nid_ext, inc_ext;

  assign {q_start, q_slot, q_key} = pop_data_i;
  assign {rd_ep, rd_key, rd_id}   = rd_q;

  assign slot_empty = rd_ep != ep_q;
  assign key_hit    = ~slot_empty & (rd_key == key_q);
  assign probe_last = probe_q == SLOT_W'(TABLE_ENTRIES - 1);
  assign slot_nx    = (slot_q == SLOT_W'(TABLE_ENTRIES - 1)) ? '0 : slot_q + 1'b1;
  assign out_free   = ~oq_v_q | group_o.ready;
  assign nid_inc    = nid_q + 1'b1;
  assign nid_ext    = {{GROUP_COUNT_W{1'b0}}, nid_q};
  assign inc_ext    = {{GROUP_COUNT_W{1'b0}}, nid_inc};

  assign pop_ready_o = state_q == ST_IDLE;
  assign init_done_o = (state_q != ST_CLR) | pend_q;

  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    pend_d    = pend_q;
    ep_d      = ep_q;
    nid_d     = nid_q;
    key_d     = key_q;
    slot_d    = slot_q;
    probe_d   = probe_q;
    mem_we    = 1'b0;
    mem_wa    = clr_idx_q;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = slot_q;
    oq_v_d    = oq_v_q & ~group_o.ready;
    oid_d     = oid_q;
    onew_d    = onew_q;
    oovf_d    = oovf_q;
    ocnt_d    = ocnt_q;

    unique case (state_q)
      ST_CLR: begin
        // write epoch zero, marking every entry empty
        mem_we = 1'b1;
        if (clr_idx_q == SLOT_W'(TABLE_ENTRIES - 1)) begin
          ep_d    = EPOCH_W'(1);
          pend_d  = 1'b0;
          state_d = pend_q ? ST_RD : ST_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (pop_valid_i) begin
          key_d   = q_key;
          slot_d  = q_slot;
          probe_d = '0;
          mem_ra  = q_slot;
          if (q_start) begin
            nid_d = '0;
            if (ep_q == {EPOCH_W{1'b1}}) begin
              clr_idx_d = '0;
              pend_d    = 1'b1;
              state_d   = ST_CLR;
            end else begin
              ep_d    = ep_q + 1'b1;
              mem_re  = 1'b1;
              state_d = ST_CMP;
            end
          end else begin
            mem_re  = 1'b1;
            state_d = ST_CMP;
          end
        end
      end
      ST_RD: begin
        mem_re  = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (slot_empty || key_hit || probe_last) begin
          if (out_free) begin
            oq_v_d  = 1'b1;
            state_d = ST_IDLE;
            if (key_hit) begin
              oid_d  = rd_id;
              onew_d = 1'b0;
              oovf_d = 1'b0;
              ocnt_d = nid_ext[GROUP_COUNT_W-1:0];
            end else if (slot_empty && (nid_q < CNT_W'(TABLE_ENTRIES))) begin
              mem_we = 1'b1;
              mem_wa = slot_q;
              mem_wd = {ep_q, key_q, nid_ext[GROUP_ID_W-1:0]};
              nid_d  = nid_inc;
              oid_d  = nid_ext[GROUP_ID_W-1:0];
              onew_d = 1'b1;
              oovf_d = 1'b0;
              ocnt_d = inc_ext[GROUP_COUNT_W-1:0];
            end else begin
              oid_d  = '0;
              onew_d = 1'b0;
              oovf_d = 1'b1;
              ocnt_d = nid_ext[GROUP_COUNT_W-1:0];
            end
          end
        end else begin
          // occupied by another key: linear probe to the next slot
          slot_d  = slot_nx;
          probe_d = probe_q + 1'b1;
          mem_re  = 1'b1;
          mem_ra  = slot_nx;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_idx_q <= '0;
      pend_q    <= 1'b0;
      ep_q      <= EPOCH_W'(1);
      nid_q     <= '0;
      oq_v_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      pend_q    <= pend_d;
      ep_q      <= ep_d;
      nid_q     <= nid_d;
      oq_v_q    <= oq_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    slot_q  <= slot_d;
    probe_q <= probe_d;
    oid_q   <= oid_d;
    onew_q  <= onew_d;
    oovf_q  <= oovf_d;
    ocnt_q  <= ocnt_d;
  end

  // key table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_ra];
    end
  end

  assign group_o.valid       = oq_v_q;
  assign group_o.group_id    = oid_q;
  assign group_o.is_new      = onew_q;
  assign group_o.overflow    = oovf_q;
  assign group_o.group_count = ocnt_q;

endmodule

`default_nettype wire

// ===== rtl/core/placement_signature_dense_id.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// placement_signature_dense_id
// dictionary encoding of placement signatures into dense group ids
// ---------------------------------------------------------------------------
// path: an accepted request passes the front pipeline, the queue, the table read and
//   the result register when the home slot answers; each extra linear probe step
//   adds a table read (up to TABLE_ENTRIES - 1 extra steps)
// requests: the back takes a new one only from idle, after the read-then-decide
//   loop for the last one on the single table read port; probes and a stalled result
//   hold it; with a table size that is no power of two the slot remainder unit
//   adds its steps and takes no new request until it has pushed its remainder
// reset: a clearing pass marks every entry empty; requests wait until it ends;
//   it reruns on every 255th start of a node set, when the epoch tag wraps
// ---------------------------------------------------------------------------
module placement_signature_dense_id import psd_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned MAX_MAPPINGS  = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [NUM_MAP_W-1:0] cfg_wdata_i,
  psd_node_if.sink             node_i,
  psd_group_if.source          group_o
);

  localparam int unsigned SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned QE_W   = 1 + SLOT_W + MAX_MAPPINGS;

  // number of mappings in the signature; values past the key width keep all bits
  logic [NUM_MAP_W-1:0] num_map_q;

  // front to queue
  logic            f_valid, f_ready;
  logic [QE_W-1:0] f_data;

  // queue to back
  logic            b_valid, b_ready;
  logic [QE_W-1:0] b_data;

  // back has finished its clearing pass after reset
  logic            init_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_map_q <= NUM_MAP_RESET;
    end else if (cfg_we_i) begin
      num_map_q <= cfg_wdata_i;
    end
  end

  // front: mask, hash and home slot for each request
  psd_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_MAPPINGS  (MAX_MAPPINGS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .init_done_i  (init_done),
    .num_map_i    (num_map_q),
    .node_i       (node_i),
    .push_valid_o (f_valid),
    .push_data_o  (f_data),
    .push_ready_i (f_ready)
  );

  // short queue lets hashing run ahead of long probe chains
  psd_fifo #(
    .WIDTH (QE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_data_i  (f_data),
    .push_ready_o (f_ready),
    .pop_valid_o  (b_valid),
    .pop_data_o   (b_data),
    .pop_ready_i  (b_ready)
  );

  // back: table probe, insert and result register
  psd_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_MAPPINGS  (MAX_MAPPINGS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (b_valid),
    .pop_data_i  (b_data),
    .pop_ready_o (b_ready),
    .init_done_o (init_done),
    .group_o     (group_o)
  );

endmodule

`default_nettype wire
